// ===== rtl/csma_mac_pkg.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller package
// Shared types, register indexes, status codes and backoff helpers.
// ----------------------------------------------------------------------------
package csma_mac_pkg;

  // Frame geometry
  localparam int MAX_FRAME_BYTES = 256;
  localparam int RX_BUF_BYTES    = 256;
  localparam int HDR_BYTES       = 6;
  localparam int MAX_PLEN        = MAX_FRAME_BYTES - HDR_BYTES;
  // Wide enough for any clamped frame length in the supported range
  localparam int LEN_W           = 11;

  // Protocol limits
  localparam int          CCA_RETRY_LIMIT = 50;
  localparam logic [15:0] BCAST_ADDR      = 16'hFFFF;
  localparam int          FLG_ACK_REQ     = 0;
  localparam int          FLG_ACK_FRAME   = 1;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDR     = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES  = 2'd2;
  localparam logic [1:0] CFG_MANAGE_TX_EN = 2'd3;

  // Event kinds
  localparam logic FUNC_SEND = 1'b0;

  // PHY transmit-done codes
  localparam logic [1:0] TXEV_NONE = 2'd0;
  localparam logic [1:0] TXEV_OK   = 2'd1;

  // Confirm status codes
  localparam logic [1:0] ST_SUCCESS    = 2'd0;
  localparam logic [1:0] ST_CH_ACCESS  = 2'd1;
  localparam logic [1:0] ST_NO_ACK     = 2'd2;
  localparam logic [1:0] ST_NO_CARRIER = 2'd3;

  // MAC mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_BACKOFF = 5'b00010,
    MODE_CCA     = 5'b00100,
    MODE_SEND    = 5'b01000,
    MODE_WAITACK = 5'b10000
  } mac_mode_e;

  // Input item without the event kind
  typedef struct packed {
    logic [15:0] dst_addr;
    logic [7:0]  payload_len;
    logic [31:0] now_ms;
    logic [8:0]  rx_len;
    logic        rx_crc_ok;
    logic [15:0] rx_dst;
    logic [15:0] rx_src;
    logic [7:0]  rx_seq;
    logic [7:0]  rx_flags;
    logic        cca_clear;
    logic [1:0]  tx_event;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        accepted;
    logic        frame_send;
    logic [7:0]  frame_seq;
    logic        ack_send;
    logic [7:0]  ack_seq;
    logic        tx_enable;
    logic        confirm_valid;
    logic [1:0]  confirm_status;
    logic [7:0]  confirm_retries;
    logic        rx_deliver;
    logic [15:0] rx_source;
    logic [8:0]  rx_payload_len;
  } res_t;

  // Backoff generator: 16-bit LCG, delay = 10 + v mod 90 ms
  localparam logic [31:0] LCG_MUL      = 32'd1103515245;
  localparam logic [31:0] LCG_INC      = 32'd12345;
  localparam int          BACKOFF_MIN  = 10;
  localparam int          BACKOFF_SPAN = 90;

  typedef logic [6:0] mod_tbl_t [256];

  // Residues of hi*256 and lo, built at elaboration
  function automatic mod_tbl_t build_hi_tbl();
    mod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 7'((i * 256) % BACKOFF_SPAN);
    end
    return t;
  endfunction

  function automatic mod_tbl_t build_lo_tbl();
    mod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = 7'(i % BACKOFF_SPAN);
    end
    return t;
  endfunction

  localparam mod_tbl_t HI_MOD_TBL = build_hi_tbl();
  localparam mod_tbl_t LO_MOD_TBL = build_lo_tbl();

  // Advance the LCG; only the low 16 bits of the product matter
  function automatic logic [15:0] lcg_step(input logic [15:0] v);
    logic [15:0] p;
    p = v * LCG_MUL[15:0];
    return p + LCG_INC[15:0];
  endfunction

  // Delay in ms for one LCG value, via two residue tables
  function automatic logic [6:0] backoff_of(input logic [15:0] v);
    logic [7:0] s;
    s = {1'b0, HI_MOD_TBL[v[15:8]]} + {1'b0, LO_MOD_TBL[v[7:0]]};
    if (s >= 8'(BACKOFF_SPAN)) begin
      s = s - 8'(BACKOFF_SPAN);
    end
    return s[6:0] + 7'(BACKOFF_MIN);
  endfunction

  // Generator state after reset: the value after 1 and its delay
  localparam logic [15:0] LCG_RST_NEXT = lcg_step(16'd1);
  localparam logic [6:0]  BACKOFF_RST  = backoff_of(LCG_RST_NEXT);

endpackage

// ===== rtl/csma_ack_mac_controller_top.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller with ACK and retry
// Stream wrapper: input register, event core, output register.
// ----------------------------------------------------------------------------
// Each input transaction is one MAC event (a send request or a poll) and
// produces exactly one result transaction. The block sustains one event per
// clock when the output side does not stall: an event is held in the input
// register, is processed by the combinational event core, and its result is
// captured in the output register, from which it is offered downstream. The
// core's state update for one event is what sets the one-per-cycle figure.
// Input and output registers decouple the two sides, so one more event is
// taken while a result waits to be taken.
// The backoff generator keeps its next delay precomputed, so a backoff poll
// compares elapsed time against a stored value while drawing the next one.
module csma_ack_mac_controller_top import csma_mac_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [15:0]  cfg_wdata_i,
  // Event stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // dst_addr[15:0], payload_len[23:16], now_ms[55:24], rx_len[64:56],
  // rx_crc_ok[65], rx_dst[81:66], rx_src[97:82], rx_seq[105:98],
  // rx_flags[113:106], cca_clear[114], tx_event[116:115], zero[119:117]
  input  logic [119:0] s_axis_tdata_i,
  // func[0]
  input  logic [0:0]   s_axis_tuser_i,
  // Result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // accepted[0], frame_send[1], frame_seq[9:2], ack_send[10], ack_seq[18:11],
  // tx_enable[19], confirm_valid[20], confirm_status[22:21],
  // confirm_retries[30:23], rx_deliver[31], rx_source[47:32],
  // rx_payload_len[56:48], zero[63:57]
  output logic [63:0]  m_axis_tdata_o
);

  logic     in_valid_q;
  logic     in_func_q;
  in_item_t in_item_q;
  logic     out_valid_q;
  res_t     out_res_q;

  logic     advance;
  logic     fire;
  logic     s_acc;
  res_t     res;

  // Handshake: the input register moves on whenever the output can take it
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_acc) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture the event payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_func_q             <= s_axis_tuser_i[0];
      in_item_q.dst_addr    <= s_axis_tdata_i[15:0];
      in_item_q.payload_len <= s_axis_tdata_i[23:16];
      in_item_q.now_ms      <= s_axis_tdata_i[55:24];
      in_item_q.rx_len      <= s_axis_tdata_i[64:56];
      in_item_q.rx_crc_ok   <= s_axis_tdata_i[65];
      in_item_q.rx_dst      <= s_axis_tdata_i[81:66];
      in_item_q.rx_src      <= s_axis_tdata_i[97:82];
      in_item_q.rx_seq      <= s_axis_tdata_i[105:98];
      in_item_q.rx_flags    <= s_axis_tdata_i[113:106];
      in_item_q.cca_clear   <= s_axis_tdata_i[114];
      in_item_q.tx_event    <= s_axis_tdata_i[116:115];
    end
  end

  csma_mac_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .func_i      (in_func_q),
    .item_i      (in_item_q),
    .res_o       (res)
  );

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0,
                            out_res_q.rx_payload_len,
                            out_res_q.rx_source,
                            out_res_q.rx_deliver,
                            out_res_q.confirm_retries,
                            out_res_q.confirm_status,
                            out_res_q.confirm_valid,
                            out_res_q.tx_enable,
                            out_res_q.ack_seq,
                            out_res_q.ack_send,
                            out_res_q.frame_seq,
                            out_res_q.frame_send,
                            out_res_q.accepted};

endmodule

// ===== rtl/csma_mac_core.sv =====
// ----------------------------------------------------------------------------
// CSMA/CA MAC event core
// Holds the configuration and MAC state and works out one event per cycle when fire_i is set.
// ----------------------------------------------------------------------------
module csma_mac_core import csma_mac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        fire_i,
  input  logic        func_i,
  input  in_item_t    item_i,
  output res_t        res_o
);

  // Configuration registers
  logic [15:0] own_addr_q, ack_timeout_q;
  logic [7:0]  max_retries_q;
  logic        manage_tx_en_q;

  // MAC state registers
  mac_mode_e   mode_q, mode_d;
  logic [15:0] pend_dst_q, pend_dst_d;
  logic [7:0]  pend_seq_q, pend_seq_d;
  logic [7:0]  next_seq_q, next_seq_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] tstart_q, tstart_d;
  logic [15:0] lcg_q, lcg_d;      // LCG value the next backoff draws
  logic [6:0]  delay_q, delay_d;  // delay that belongs to lcg_q
  logic        started_q, started_d;
  logic        pa_q, pa_d;

  res_t        res;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q     <= '0;
      ack_timeout_q  <= 16'd100;
      max_retries_q  <= 8'd3;
      manage_tx_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_OWN_ADDR:     own_addr_q     <= cfg_wdata_i;
        CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_wdata_i;
        CFG_MAX_RETRIES:  max_retries_q  <= cfg_wdata_i[7:0];
        CFG_MANAGE_TX_EN: manage_tx_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Work out one event
  always_comb begin
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] pl;
    logic             match;
    logic [31:0]      elapsed;

    res        = '0;
    pend_dst_d = pend_dst_q;
    pend_seq_d = pend_seq_q;
    next_seq_d = next_seq_q;
    retry_d    = retry_q;
    tstart_d   = tstart_q;
    lcg_d      = lcg_q;
    delay_d    = delay_q;
    started_d  = started_q;
    pa_d       = pa_q;
    rlen       = '0;
    pl         = '0;
    match      = 1'b0;
    elapsed    = item_i.now_ms - tstart_q;

    // Fold stray mode codes into idle
    case (mode_q)
      MODE_IDLE, MODE_BACKOFF, MODE_CCA, MODE_SEND, MODE_WAITACK: mode_d = mode_q;
      default: mode_d = MODE_IDLE;
    endcase

    if (func_i == FUNC_SEND) begin
      // Queue a data frame if idle and the length is valid
      if (item_i.payload_len != 8'd0 && int'(item_i.payload_len) <= MAX_PLEN &&
          mode_d == MODE_IDLE) begin
        pend_dst_d   = item_i.dst_addr;
        pend_seq_d   = next_seq_q;
        next_seq_d   = next_seq_q + 8'd1;
        retry_d      = '0;
        started_d    = 1'b0;
        mode_d       = MODE_BACKOFF;
        tstart_d     = item_i.now_ms;
        res.accepted = 1'b1;
      end
    end else begin
      // Received frame header
      if (int'(item_i.rx_len) > MAX_FRAME_BYTES) begin
        rlen = LEN_W'(MAX_FRAME_BYTES);
      end else begin
        rlen = LEN_W'(item_i.rx_len);
      end
      match = (int'(rlen) >= HDR_BYTES) && item_i.rx_crc_ok &&
              (item_i.rx_dst == own_addr_q || item_i.rx_dst == BCAST_ADDR);
      if (match) begin
        if (item_i.rx_flags[FLG_ACK_FRAME]) begin
          if (mode_d == MODE_WAITACK && pend_dst_q == item_i.rx_src &&
              pend_seq_q == item_i.rx_seq) begin
            res.confirm_valid   = 1'b1;
            res.confirm_status  = ST_SUCCESS;
            res.confirm_retries = retry_d;
            mode_d              = MODE_IDLE;
          end
        end else begin
          pl = rlen - LEN_W'(HDR_BYTES);
          if (int'(pl) > RX_BUF_BYTES) begin
            pl = LEN_W'(RX_BUF_BYTES);
          end
          res.rx_deliver     = 1'b1;
          res.rx_source      = item_i.rx_src;
          res.rx_payload_len = pl[8:0];
          if (item_i.rx_flags[FLG_ACK_REQ]) begin
            res.ack_send = 1'b1;
            res.ack_seq  = item_i.rx_seq;
            if (manage_tx_en_q) pa_d = 1'b0;
          end
        end
      end

      // Transmit state machine
      case (mode_d)
        MODE_BACKOFF: begin
          // Every backoff poll draws a new delay
          lcg_d   = lcg_step(lcg_q);
          delay_d = backoff_of(lcg_d);
          if (elapsed >= {25'd0, delay_q}) begin
            mode_d   = MODE_CCA;
            tstart_d = item_i.now_ms;
          end
        end
        MODE_CCA: begin
          if (item_i.cca_clear) begin
            mode_d = MODE_SEND;
          end else begin
            retry_d = retry_d + 8'd1;
            if (int'(retry_d) > CCA_RETRY_LIMIT) begin
              res.confirm_valid   = 1'b1;
              res.confirm_status  = ST_CH_ACCESS;
              res.confirm_retries = retry_d;
              mode_d              = MODE_IDLE;
            end else begin
              mode_d   = MODE_BACKOFF;
              tstart_d = item_i.now_ms;
            end
          end
        end
        MODE_SEND: begin
          if (manage_tx_en_q) pa_d = 1'b1;
          res.frame_send = 1'b1;
          res.frame_seq  = pend_seq_q;
          started_d      = 1'b1;
          retry_d        = '0;
          mode_d         = MODE_WAITACK;
          tstart_d       = item_i.now_ms;
        end
        MODE_WAITACK: begin
          if (elapsed >= {16'd0, ack_timeout_q}) begin
            if (manage_tx_en_q && started_d) begin
              pa_d      = 1'b0;
              started_d = 1'b0;
            end
            res.confirm_valid   = 1'b1;
            res.confirm_status  = ST_NO_ACK;
            res.confirm_retries = retry_d;
            mode_d              = MODE_IDLE;
          end
        end
        default: ;
      endcase

      // PHY transmit done
      if (item_i.tx_event != TXEV_NONE) begin
        if (manage_tx_en_q && started_d) begin
          pa_d      = 1'b0;
          started_d = 1'b0;
        end
        if (mode_d == MODE_WAITACK && item_i.tx_event != TXEV_OK) begin
          retry_d = retry_d + 8'd1;
          if (retry_d <= max_retries_q) begin
            mode_d   = MODE_BACKOFF;
            tstart_d = item_i.now_ms;
          end else begin
            res.confirm_valid   = 1'b1;
            res.confirm_status  = ST_NO_CARRIER;
            res.confirm_retries = retry_d;
            mode_d              = MODE_IDLE;
          end
        end
      end
    end

    res.tx_enable = pa_d;
  end

  // Commit state on each processed event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      pend_dst_q <= '0;
      pend_seq_q <= '0;
      next_seq_q <= '0;
      retry_q    <= '0;
      tstart_q   <= '0;
      lcg_q      <= LCG_RST_NEXT;
      delay_q    <= BACKOFF_RST;
      started_q  <= 1'b0;
      pa_q       <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      pend_dst_q <= pend_dst_d;
      pend_seq_q <= pend_seq_d;
      next_seq_q <= next_seq_d;
      retry_q    <= retry_d;
      tstart_q   <= tstart_d;
      lcg_q      <= lcg_d;
      delay_q    <= delay_d;
      started_q  <= started_d;
      pa_q       <= pa_d;
    end
  end

  assign res_o = res;

endmodule
